// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants and types for the text console writer: screen geometry,
// cell format, character codes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLS   = 80;
  localparam int LINES  = 25;
  localparam int CELLS  = COLS * LINES;
  localparam int COPY_N = COLS * (LINES - 1);

  localparam int CUR_W  = 11;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLS);

  localparam logic [CELL_W-1:0] ATTR  = 16'h0F00;
  localparam logic [CELL_W-1:0] BLANK = 16'h0F20;

  localparam logic              OP_WRITE     = 1'b0;
  localparam logic              OP_READ      = 1'b1;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_BLANK,
    S_DONE
  } state_t;

endpackage

// ===== rtl/tcw_req_if.sv =====
// ----------------------------------------------------------------------------
// tcw_req_if
// Request channel: write a character or read one screen cell.
// ----------------------------------------------------------------------------
interface tcw_req_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [tcw_pkg::CHAR_W-1:0]   char_code;
  logic [tcw_pkg::CUR_W-1:0]    read_index;

  modport source (output valid, op, char_code, read_index, input ready);
  modport sink   (input valid, op, char_code, read_index, output ready);
endinterface

// ===== rtl/tcw_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tcw_rsp_if
// Response channel: cursor after the item, read cell, scroll flag.
// ----------------------------------------------------------------------------
interface tcw_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::CUR_W-1:0]    cursor;
  logic [tcw_pkg::CELL_W-1:0]   cell_value;
  logic                         scrolled;

  modport source (output valid, cursor, cell_value, scrolled, input ready);
  modport sink   (input valid, cursor, cell_value, scrolled, output ready);
endinterface

// ===== rtl/text_console_writer_top.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_top
// Character-cell console: screen RAM plus a sequencer for writes, reads,
// scrolling and the post-reset clear.
// ----------------------------------------------------------------------------
// Read item: the cell is read on accept; S_READ takes the registered RAM data.
// Write item: a printable char is stored on accept; S_DONE blanks the cursor cell.
// Write that scrolls: S_SCROLL copies the rows up, and the row copy moves one
// cell per cycle through the single RAM read port; S_BLANK clears the last row.
// After reset a clear pass fills all CELLS (2000) cells with blanks, one per
// cycle; no item is accepted until it completes. Cursor resets to 0.
module text_console_writer_top (
  input logic     clk,
  input logic     rst,
  tcw_req_if.sink req,
  tcw_rsp_if.source rsp
);

  localparam int PW = tcw_pkg::CUR_W + 1;

  tcw_pkg::state_t state, state_next;

  logic [tcw_pkg::CUR_W-1:0] pos, pos_next;
  logic [tcw_pkg::COL_W-1:0] col, col_next;
  logic [tcw_pkg::CNT_W-1:0] cnt, cnt_next;
  logic                      scr, scr_next;
  logic                      rd_ok, rd_ok_next;

  logic                       out_valid;
  logic [tcw_pkg::CUR_W-1:0]  out_cursor;
  logic [tcw_pkg::CELL_W-1:0] out_cell;
  logic                       out_scr;

  logic                        out_free;
  logic                        load;
  logic [tcw_pkg::CELL_W-1:0]  load_cell;
  logic                        load_scr;

  logic                        ram_we;
  logic [tcw_pkg::ADDR_W-1:0]  ram_waddr;
  logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
  logic                        ram_re;
  logic [tcw_pkg::ADDR_W-1:0]  ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

  // cursor candidates for a write item
  logic [PW-1:0]             pos_ext, pos_new;
  logic [tcw_pkg::COL_W-1:0] col_new;
  logic                      wrap;

  tcw_screen_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid || rsp.ready;
  assign pos_ext  = {1'b0, pos};

  always_comb begin
    if (req.char_code == tcw_pkg::CH_NEWLINE) begin
      pos_new = pos_ext + PW'(tcw_pkg::COLS) - PW'(col);
      col_new = '0;
    end else if (req.char_code == tcw_pkg::CH_BACKSPACE) begin
      if (pos == '0) begin
        pos_new = pos_ext;
        col_new = col;
      end else begin
        pos_new = pos_ext - PW'(1);
        col_new = (col == '0) ? tcw_pkg::COL_W'(tcw_pkg::COLS - 1) : col - 1'b1;
      end
    end else begin
      pos_new = pos_ext + PW'(1);
      col_new = (col == tcw_pkg::COL_W'(tcw_pkg::COLS - 1)) ? '0 : col + 1'b1;
    end
  end

  assign wrap = (pos_new >= PW'(tcw_pkg::CELLS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::S_CLEAR;
      pos   <= '0;
      col   <= '0;
      cnt   <= '0;
      scr   <= 1'b0;
      rd_ok <= 1'b0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      col   <= col_next;
      cnt   <= cnt_next;
      scr   <= scr_next;
      rd_ok <= rd_ok_next;
    end
  end

  always_comb begin
    state_next = state;
    pos_next   = pos;
    col_next   = col;
    cnt_next   = cnt;
    scr_next   = scr;
    rd_ok_next = rd_ok;
    ram_we     = 1'b0;
    ram_waddr  = tcw_pkg::ADDR_W'(pos);
    ram_wdata  = tcw_pkg::BLANK;
    ram_re     = 1'b0;
    ram_raddr  = tcw_pkg::ADDR_W'(req.read_index);
    load       = 1'b0;
    load_cell  = '0;
    load_scr   = 1'b0;

    unique case (state)
      tcw_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[tcw_pkg::ADDR_W-1:0];
        if (cnt == tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1)) begin
          cnt_next   = '0;
          state_next = tcw_pkg::S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      tcw_pkg::S_IDLE: begin
        if (req.valid) begin
          if (req.op == tcw_pkg::OP_READ) begin
            rd_ok_next = (req.read_index < tcw_pkg::CUR_W'(tcw_pkg::CELLS));
            ram_re     = rd_ok_next;
            state_next = tcw_pkg::S_READ;
          end else begin
            if (req.char_code != tcw_pkg::CH_NEWLINE &&
                req.char_code != tcw_pkg::CH_BACKSPACE) begin
              ram_we    = 1'b1;
              ram_wdata = tcw_pkg::ATTR | tcw_pkg::CELL_W'(req.char_code);
            end
            col_next = col_new;
            scr_next = wrap;
            if (wrap) begin
              pos_next   = tcw_pkg::CUR_W'(pos_new - PW'(tcw_pkg::COLS));
              cnt_next   = '0;
              state_next = tcw_pkg::S_SCROLL;
            end else begin
              pos_next   = tcw_pkg::CUR_W'(pos_new);
              state_next = tcw_pkg::S_DONE;
            end
          end
        end
      end

      tcw_pkg::S_READ: begin
        if (out_free) begin
          load       = 1'b1;
          load_cell  = rd_ok ? ram_rdata : '0;
          state_next = tcw_pkg::S_IDLE;
        end
      end

      // copy pipeline: read cell cnt+COLS, write last cycle's data to cnt-1
      tcw_pkg::S_SCROLL: begin
        if (cnt < tcw_pkg::CNT_W'(tcw_pkg::COPY_N)) begin
          ram_re    = 1'b1;
          ram_raddr = tcw_pkg::ADDR_W'(cnt + tcw_pkg::CNT_W'(tcw_pkg::COLS));
        end
        if (cnt != '0) begin
          ram_we    = 1'b1;
          ram_waddr = tcw_pkg::ADDR_W'(cnt - 1'b1);
          ram_wdata = ram_rdata;
        end
        if (cnt == tcw_pkg::CNT_W'(tcw_pkg::COPY_N)) begin
          state_next = tcw_pkg::S_BLANK;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      tcw_pkg::S_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[tcw_pkg::ADDR_W-1:0];
        if (cnt == tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1)) begin
          cnt_next   = '0;
          state_next = tcw_pkg::S_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      // blank under the cursor; repeating the write while stalled is harmless
      tcw_pkg::S_DONE: begin
        ram_we = 1'b1;
        if (out_free) begin
          load       = 1'b1;
          load_scr   = scr;
          state_next = tcw_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = tcw_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_cursor <= pos;
      out_cell   <= load_cell;
      out_scr    <= load_scr;
    end
  end

  assign req.ready      = (state == tcw_pkg::S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.cursor     = out_cursor;
  assign rsp.cell_value = out_cell;
  assign rsp.scrolled   = out_scr;

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("second item accepted before the first finished");

  a_scroll_last_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_scr |-> out_cursor >= tcw_pkg::CUR_W'(tcw_pkg::CELLS - tcw_pkg::COLS))
    else $error("scrolled result with cursor above the last row");

  a_copy_order: assert property (@(posedge clk) disable iff (rst)
    state == tcw_pkg::S_SCROLL && ram_we && ram_re |-> ram_waddr < ram_raddr)
    else $error("scroll copy writes at or past its read address");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    pos < tcw_pkg::CUR_W'(tcw_pkg::CELLS) && col < tcw_pkg::COL_W'(tcw_pkg::COLS))
    else $error("cursor or column out of range");

endmodule

// ===== rtl/tcw_screen_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text console writer. Character writes and cell
// reads go in through the request channel with random gaps. A scoreboard keeps
// its own screen and cursor, predicts every reply in order, and compares each
// reply field by field. The receiver stalls at random and holds off once for
// a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [tcw_pkg::CUR_W-1:0]  cursor;
    logic [tcw_pkg::CELL_W-1:0] cell_value;
    logic                       scrolled;
  } reply_t;

  class console_scoreboard;
    logic [tcw_pkg::CELL_W-1:0] screen [tcw_pkg::CELLS];
    int                         cursor_pos;
    reply_t                     pending_replies[$];
    int                         errors;

    function new();
      foreach (screen[i]) screen[i] = tcw_pkg::BLANK;
      cursor_pos = 0;
      errors     = 0;
    endfunction

    // applies one request to the shadow screen and returns the reply it causes
    function reply_t console_effect(logic op, logic [tcw_pkg::CHAR_W-1:0] ch,
                                    logic [tcw_pkg::CUR_W-1:0] idx);
      reply_t r;
      int     pos;
      r   = '0;
      pos = cursor_pos;
      if (pos >= tcw_pkg::CELLS) pos = 0;
      if (op == tcw_pkg::OP_READ) begin
        r.cursor     = tcw_pkg::CUR_W'(pos);
        r.cell_value = (idx < tcw_pkg::CELLS) ? screen[idx] : '0;
        return r;
      end
      if (ch == tcw_pkg::CH_NEWLINE) begin
        pos += tcw_pkg::COLS - pos % tcw_pkg::COLS;
      end else if (ch == tcw_pkg::CH_BACKSPACE) begin
        if (pos > 0) pos--;
      end else begin
        screen[pos] = tcw_pkg::ATTR | {{(tcw_pkg::CELL_W-tcw_pkg::CHAR_W){1'b0}}, ch};
        pos++;
      end
      if (pos >= tcw_pkg::CELLS) begin
        for (int i = 0; i < tcw_pkg::COPY_N; i++) screen[i] = screen[i + tcw_pkg::COLS];
        for (int i = tcw_pkg::COPY_N; i < tcw_pkg::CELLS; i++) screen[i] = tcw_pkg::BLANK;
        pos -= tcw_pkg::COLS;
        r.scrolled = 1'b1;
      end
      cursor_pos  = pos;
      screen[pos] = tcw_pkg::BLANK;
      r.cursor    = tcw_pkg::CUR_W'(pos);
      return r;
    endfunction

    function void note_request(logic op, logic [tcw_pkg::CHAR_W-1:0] ch,
                               logic [tcw_pkg::CUR_W-1:0] idx);
      pending_replies.push_back(console_effect(op, ch, idx));
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $error("reply with nothing expected: cursor %0d cell %h scrolled %0b",
               got.cursor, got.cell_value, got.scrolled);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.cursor !== want.cursor) begin
        $error("cursor: expected %0d, got %0d", want.cursor, got.cursor);
        errors++;
      end
      if (got.cell_value !== want.cell_value) begin
        $error("cell_value: expected %h, got %h", want.cell_value, got.cell_value);
        errors++;
      end
      if (got.scrolled !== want.scrolled) begin
        $error("scrolled: expected %0b, got %0b", want.scrolled, got.scrolled);
        errors++;
      end
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction
  endclass

  localparam int RANDOM_ITEMS = 1300;
  localparam int CALM_TAIL    = 150;
  localparam int IDX_MAX      = (1 << tcw_pkg::CUR_W) - 1;

  logic clk;
  logic rst;

  tcw_req_if req_ch ();
  tcw_rsp_if rsp_ch ();

  text_console_writer_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  console_scoreboard console = new();

  bit calm;
  bit tx_idle_on;
  bit rx_idle_on;
  int rsp_hold;
  int replies_seen;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // the timeout is set above the slowest legal run: every item scrolling plus
  // both sides' longest bursts
  initial begin
    #100_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic offer_item(input logic op, input logic [tcw_pkg::CHAR_W-1:0] ch,
                            input logic [tcw_pkg::CUR_W-1:0] idx);
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.char_code  <= ch;
    req_ch.read_index <= idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    console.note_request(op, ch, idx);
  endtask

  task automatic pause_requests(input int cycles);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic put_char(input logic [tcw_pkg::CHAR_W-1:0] ch);
    offer_item(tcw_pkg::OP_WRITE, ch, tcw_pkg::CUR_W'($urandom_range(0, IDX_MAX)));
  endtask

  task automatic read_cell(input logic [tcw_pkg::CUR_W-1:0] idx);
    offer_item(tcw_pkg::OP_READ, tcw_pkg::CHAR_W'($urandom_range(0, 255)), idx);
  endtask

  // response side: random stall bursts plus one long hold-off
  initial begin
    reply_t got;
    rsp_ch.ready = 1'b0;
    rsp_hold     = 0;
    replies_seen = 0;
    rx_idle_on   = 1'b1;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) == 0) rx_idle_on = !rx_idle_on;
      if (rsp_hold > 0) begin
        rsp_ch.ready <= 1'b0;
        rsp_hold--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (rx_idle_on && !calm && $urandom_range(0, 3) == 0)
          rsp_hold = $urandom_range(1, 13);
      end
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.cursor     = rsp_ch.cursor;
        got.cell_value = rsp_ch.cell_value;
        got.scrolled   = rsp_ch.scrolled;
        console.check_reply(got);
        replies_seen++;
        // long hold while the sender keeps pushing
        if (replies_seen == 200) rsp_hold = 300;
      end
    end
  end

  initial begin
    logic [tcw_pkg::CHAR_W-1:0] ch;
    logic [tcw_pkg::CUR_W-1:0]  idx;
    int                         pick;

    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.op         = tcw_pkg::OP_WRITE;
    req_ch.char_code  = '0;
    req_ch.read_index = '0;
    calm              = 1'b0;
    tx_idle_on        = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: backspace at the first cell, byte extremes, read range edges,
    // newline, backspace across a row boundary
    put_char(tcw_pkg::CH_BACKSPACE);
    offer_item(tcw_pkg::OP_READ, 8'hFF, '0);
    put_char(8'h00);
    put_char(8'hFF);
    read_cell(tcw_pkg::CUR_W'(0));
    read_cell(tcw_pkg::CUR_W'(1));
    read_cell(tcw_pkg::CUR_W'(2));
    read_cell(tcw_pkg::CUR_W'(tcw_pkg::CELLS - 1));
    read_cell(tcw_pkg::CUR_W'(tcw_pkg::CELLS));
    offer_item(tcw_pkg::OP_READ, 8'h00, tcw_pkg::CUR_W'(IDX_MAX));
    put_char(tcw_pkg::CH_NEWLINE);
    put_char(tcw_pkg::CH_BACKSPACE);
    put_char(8'h7F);
    read_cell(tcw_pkg::CUR_W'(tcw_pkg::COLS - 1));
    offer_item(tcw_pkg::OP_WRITE, tcw_pkg::CH_NEWLINE, tcw_pkg::CUR_W'(IDX_MAX));
    put_char(8'h20);
    put_char(8'h41);
    read_cell(tcw_pkg::CUR_W'(tcw_pkg::COLS + 1));
    put_char(tcw_pkg::CH_BACKSPACE);
    put_char(tcw_pkg::CH_BACKSPACE);
    put_char(tcw_pkg::CH_BACKSPACE);
    read_cell(tcw_pkg::CUR_W'(tcw_pkg::COLS - 1));
    read_cell(tcw_pkg::CUR_W'(tcw_pkg::COLS));

    // random text with newlines and backspaces, mixed with cell reads
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_TAIL) calm = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 15) == 0)
          idx = tcw_pkg::CUR_W'($urandom_range(tcw_pkg::CELLS, IDX_MAX));
        else idx = tcw_pkg::CUR_W'($urandom_range(0, tcw_pkg::CELLS - 1));
        read_cell(idx);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 12) ch = tcw_pkg::CH_NEWLINE;
        else if (pick < 18) ch = tcw_pkg::CH_BACKSPACE;
        else ch = tcw_pkg::CHAR_W'($urandom_range(0, 255));
        put_char(ch);
      end
      if ($urandom_range(0, 39) == 0) tx_idle_on = !tx_idle_on;
      if (tx_idle_on && !calm && $urandom_range(0, 2) == 0)
        pause_requests($urandom_range(1, 13));
    end
    @(negedge clk);
    req_ch.valid <= 1'b0;

    while (console.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (console.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
